// ----- hdl/bounded_array_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// Bounded array list engine: assertion macros
// Concurrent checks on the rising edge of clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define BALE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bale_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded array list engine package
// Field widths, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package bale_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 6;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_GET    = 3'd2,
    OP_INDEX  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

// ----- hdl/bale_if.sv -----
// ----------------------------------------------------------------------------
// Bounded array list engine channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bale_in_if import bale_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   index;
  logic [VALUE_W-1:0] value;

  modport source (output valid, operation, index, value, input ready);
  modport sink (input valid, operation, index, value, output ready);
endinterface

interface bale_out_if import bale_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [VALUE_W-1:0] data;
  logic [POS_W-1:0]   position;
  logic [CNT_W-1:0]   count;

  modport source (output valid, status, data, position, count, input ready);
  modport sink (input valid, status, data, position, count, output ready);
endinterface

// ----- hdl/bale_store.sv -----
// ----------------------------------------------------------------------------
// Bounded array list engine store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bale_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/bounded_array_list_engine.sv -----
// ----------------------------------------------------------------------------
// Bounded array list engine
// Ordered list of up to CAPACITY words with append, insert, get, index-of,
// remove and clear, walked one entry per cycle through a two-port store.
// ----------------------------------------------------------------------------
// Usage:
//   in_if takes one operation per item (operation, index, value); out_if
//   returns exactly one result per item (status, data, position, count).
//   An item is taken when valid and ready are both high; in_if.ready is
//   high only while the engine is idle, one item at a time.
//   After the item is taken, a decode state runs; append, clear, bad index,
//   full, an unknown code and index-of on an empty list go from there
//   straight to the done state, which loads the result. Get waits on the
//   store's registered read first. Insert and remove shift every entry from
//   index to the end; index-of compares entries from position zero until a
//   hit or the end of the list. The walks are set by the store's single
//   read and single write port: every shift or compare moves one entry. The
//   next item can be taken at the edge after the result loads.
//   The result sits in an output register; while out_if.ready is low the
//   next item is still accepted and processed, and its result waits in a
//   done state until the register frees.
//   Reset empties the list (count zero) and drops any held result; the
//   stored words are left as they were and are never read unwritten.
// ----------------------------------------------------------------------------
`include "bounded_array_list_engine_defines.svh"

module bounded_array_list_engine import bale_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bale_in_if.sink    in_if,
  bale_out_if.source out_if
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_GET_WAIT,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SEARCH,
    S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] word_r, word_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         paddr_r, paddr_nxt;
  logic                  last_r, last_nxt;
  logic [STAT_W-1:0]     res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]    res_data_r, res_data_nxt;
  logic [POS_W-1:0]      res_pos_r, res_pos_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]    out_data_r, out_data_nxt;
  logic [POS_W-1:0]      out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]      out_count_r, out_count_nxt;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  in_take;
  logic                  out_free;
  logic                  full;
  logic                  bad_idx;
  logic [AW-1:0]         idx_a;
  logic [AW-1:0]         cnt_m1_a;
  logic                  walking;

  bale_store #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_if.ready     = (state_r == S_IDLE);
  assign in_take         = in_if.valid && in_if.ready;
  assign out_free        = !out_valid_r || out_if.ready;
  assign full            = (count_r == CW'(CAPACITY));
  assign bad_idx         = (XW'(idx_r) >= XW'(count_r));
  assign idx_a           = AW'(idx_r);
  assign cnt_m1_a        = AW'(count_r - CW'(1));
  assign walking         = (state_r == S_SHIFT_UP) || (state_r == S_SHIFT_DN) ||
                           (state_r == S_SEARCH);

  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_status_r;
  assign out_if.data     = out_data_r;
  assign out_if.position = out_pos_r;
  assign out_if.count    = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    word_nxt       = word_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    paddr_nxt      = paddr_r;
    last_nxt       = last_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = paddr_r;
    wr_data        = rd_data;
    rd_addr        = ptr_r;

    // issue one read per cycle along the walk
    if (walking) begin
      if (!last_r) begin
        pend_nxt  = 1'b1;
        paddr_nxt = ptr_r;
        if (state_r == S_SHIFT_UP) begin
          if (ptr_r == idx_a) last_nxt = 1'b1;
          else ptr_nxt = ptr_r - AW'(1);
        end else begin
          if (ptr_r == cnt_m1_a) last_nxt = 1'b1;
          else ptr_nxt = ptr_r + AW'(1);
        end
      end else begin
        pend_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_nxt    = in_if.operation;
          idx_nxt   = in_if.index;
          word_nxt  = DATA_WIDTH'(in_if.value);
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_nxt = ST_OK;
        res_data_nxt   = '0;
        res_pos_nxt    = '0;
        pend_nxt       = 1'b0;
        last_nxt       = 1'b0;
        state_nxt      = S_DONE;
        unique case (op_r)
          OP_APPEND: begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = AW'(count_r);
              wr_data   = word_r;
              count_nxt = count_r + CW'(1);
            end
          end
          OP_INSERT: begin
            if (bad_idx) begin
              res_status_nxt = ST_BAD_INDEX;
            end else if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              ptr_nxt   = cnt_m1_a;
              state_nxt = S_SHIFT_UP;
            end
          end
          OP_GET: begin
            if (bad_idx) begin
              res_status_nxt = ST_BAD_INDEX;
            end else begin
              rd_addr   = idx_a;
              state_nxt = S_GET_WAIT;
            end
          end
          OP_INDEX: begin
            if (count_r == '0) begin
              res_status_nxt = ST_NOT_FOUND;
            end else begin
              ptr_nxt   = '0;
              state_nxt = S_SEARCH;
            end
          end
          OP_REMOVE: begin
            if (bad_idx) begin
              res_status_nxt = ST_BAD_INDEX;
            end else begin
              ptr_nxt   = idx_a;
              state_nxt = S_SHIFT_DN;
            end
          end
          OP_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end
      S_GET_WAIT: begin
        res_data_nxt = VALUE_W'(rd_data);
        state_nxt    = S_DONE;
      end
      S_SHIFT_UP: begin
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = paddr_r + AW'(1);
        end else if (last_r) begin
          wr_en     = 1'b1;
          wr_addr   = idx_a;
          wr_data   = word_r;
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        if (pend_r) begin
          if (paddr_r == idx_a) begin
            res_data_nxt = VALUE_W'(rd_data);
          end else begin
            wr_en   = 1'b1;
            wr_addr = paddr_r - AW'(1);
          end
        end else if (last_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_SEARCH: begin
        if (pend_r && (rd_data == word_r)) begin
          res_pos_nxt = POS_W'(paddr_r);
          state_nxt   = S_DONE;
        end else if (!pend_r && last_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          out_pos_nxt    = res_pos_r;
          out_count_nxt  = CNT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    word_r       <= word_nxt;
    ptr_r        <= ptr_nxt;
    paddr_r      <= paddr_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  `BALE_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count above capacity")
  `BALE_ASSERT_NOW(a_write_busy, wr_en, (state_r != S_IDLE) && (state_r != S_DONE), "store write while idle")
  `BALE_ASSERT_NOW(a_write_range, wr_en, int'(wr_addr) < CAPACITY, "store write out of range")
  `BALE_ASSERT_NEXT(a_done_emit, (state_r == S_DONE) && out_free, out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule
